@@ rtl/fbpa_pkg.sv @@
// Shared constants and codes for the fixed block pool allocator.
package fbpa_pkg;

  // Pool geometry.
  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int CMD_W      = 2;
  localparam int ST_W       = 2;

  // Command codes carried on the input tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT = 2'd0,
    CMD_GET  = 2'd1,
    CMD_PUT  = 2'd2
  } cmd_t;

  // Status codes carried on the output tuser.
  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_PUT = 2'd2
  } status_t;

endpackage

@@ rtl/fixed_block_pool_allocator_top.sv @@
// Top level of the fixed block pool allocator: free list memory and command pipeline.

// The pool keeps its free blocks as a linked list in a 256 x 8 link memory
// with a registered read. For each command beat, the cycle of acceptance
// issues the read of the link behind the current head; the command stage
// then updates head, free count and the link memory and loads the result
// register, stalling while a result still waits on the output. A new beat
// is taken only once that update is done, so the block holds one command
// at a time. The result register lets the next command enter while
// a result still waits on the output. Init clears every per-entry written
// flag at once; an entry never written since init reads as its ascending
// chain value, so there is no clearing pass after reset or init.
module fixed_block_pool_allocator_top (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration: block count taken by the next init.
  input  logic                         cfg_we,
  input  logic [fbpa_pkg::CNT_W-1:0]   cfg_wdata,
  // Command input.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] block_index
  input  logic [fbpa_pkg::CMD_W-1:0]   s_axis_tuser,  // [1:0] command
  // Result output.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,  // [7:0] granted_index, [16:8] free_count
  output logic [fbpa_pkg::ST_W-1:0]    m_axis_tuser   // [1:0] status
);

  localparam int IDX_W = fbpa_pkg::IDX_W;
  localparam int CNT_W = fbpa_pkg::CNT_W;

  // Link memory and per-entry written flags.
  logic [IDX_W-1:0]            link_mem [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::MAX_BLOCKS-1:0] link_written;

  // Pool state.
  logic [CNT_W-1:0] block_count;
  logic [CNT_W-1:0] pool_size;
  logic [CNT_W-1:0] free_blocks;
  logic [IDX_W-1:0] head_index;

  // Command stage.
  logic                       exec_vld;
  logic [fbpa_pkg::CMD_W-1:0] exec_cmd;
  logic [IDX_W-1:0]           exec_idx;
  logic [IDX_W-1:0]           link_rdata;
  logic                       link_rvld;

  // Result register.
  logic                       out_vld;
  logic [IDX_W-1:0]           out_granted;
  logic [fbpa_pkg::ST_W-1:0]  out_status;
  logic [CNT_W-1:0]           out_free;

  // Update values.
  logic                       s_beat;
  logic                       exec_done;
  logic [IDX_W-1:0]           head_link;
  logic [CNT_W-1:0]           init_count;
  logic [CNT_W-1:0]           free_dec;
  logic [IDX_W-1:0]           head_index_next;
  logic [CNT_W-1:0]           free_blocks_next;
  logic [CNT_W-1:0]           pool_size_next;
  logic [IDX_W-1:0]           granted_next;
  logic [fbpa_pkg::ST_W-1:0]  status_next;
  logic                       do_init;
  logic                       do_put;

  // Handshakes: one command in flight, result register drains in parallel.
  assign s_axis_tready = !exec_vld;
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign exec_done     = exec_vld && (!out_vld || m_axis_tready);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= CNT_W'(fbpa_pkg::MAX_BLOCKS);
    end else if (cfg_we) begin
      block_count <= cfg_wdata;
    end
  end

  // Link memory: read the head's link on acceptance, write on a good put.
  always_ff @(posedge clk) begin
    if (s_beat) begin
      link_rdata <= link_mem[head_index];
    end
    if (exec_done && do_put) begin
      link_mem[exec_idx] <= head_index;
    end
  end

  // Written flags; an unwritten entry holds its ascending chain value.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_written <= '0;
    end else if (exec_done && do_init) begin
      link_written <= '0;
    end else if (exec_done && do_put) begin
      link_written[exec_idx] <= 1'b1;
    end
  end

  // Command stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      exec_vld <= 1'b0;
    end else if (s_beat) begin
      exec_vld <= 1'b1;
    end else if (exec_done) begin
      exec_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat) begin
      exec_cmd  <= s_axis_tuser;
      exec_idx  <= s_axis_tdata[IDX_W-1:0];
      link_rvld <= link_written[head_index];
    end
  end

  // Command decode and next pool state.
  always_comb begin
    head_link  = link_rvld ? link_rdata : head_index + IDX_W'(1);
    init_count = (block_count > CNT_W'(fbpa_pkg::MAX_BLOCKS)) ?
                 CNT_W'(fbpa_pkg::MAX_BLOCKS) : block_count;
    free_dec   = free_blocks - CNT_W'(1);

    head_index_next  = head_index;
    free_blocks_next = free_blocks;
    pool_size_next   = pool_size;
    granted_next     = '0;
    status_next      = fbpa_pkg::ST_OK;
    do_init          = 1'b0;
    do_put           = 1'b0;

    unique case (exec_cmd)
      fbpa_pkg::CMD_INIT: begin
        do_init          = 1'b1;
        head_index_next  = '0;
        free_blocks_next = init_count;
        pool_size_next   = init_count;
      end
      fbpa_pkg::CMD_GET: begin
        if (free_blocks == '0) begin
          status_next = fbpa_pkg::ST_EMPTY;
        end else begin
          granted_next     = head_index;
          free_blocks_next = free_dec;
          if (free_dec != '0) begin
            head_index_next = head_link;
          end
        end
      end
      fbpa_pkg::CMD_PUT: begin
        if ({1'b0, exec_idx} >= pool_size || free_blocks >= pool_size) begin
          status_next = fbpa_pkg::ST_BAD_PUT;
        end else begin
          do_put           = 1'b1;
          head_index_next  = exec_idx;
          free_blocks_next = free_blocks + CNT_W'(1);
        end
      end
      default: begin
        status_next = fbpa_pkg::ST_BAD_PUT;
      end
    endcase
  end

  // Pool state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index  <= '0;
      free_blocks <= CNT_W'(fbpa_pkg::MAX_BLOCKS);
      pool_size   <= CNT_W'(fbpa_pkg::MAX_BLOCKS);
    end else if (exec_done) begin
      head_index  <= head_index_next;
      free_blocks <= free_blocks_next;
      pool_size   <= pool_size_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (exec_done) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_granted <= granted_next;
      out_status  <= status_next;
      out_free    <= free_blocks_next;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {7'd0, out_free, out_granted};
  assign m_axis_tuser  = out_status;

  // The free count never exceeds the pool size taken at init.
  assert property (@(posedge clk) disable iff (rst) free_blocks <= pool_size)
    else $error("free count above pool size");

  // An empty report carries no grant and a zero free count.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == fbpa_pkg::ST_EMPTY |->
      m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[16:8] == 9'd0)
    else $error("empty status with grant or nonzero count");

  // A finished command always lands in the result register.
  assert property (@(posedge clk) disable iff (rst) exec_done |=> out_vld)
    else $error("completed command lost its result");

  // A successful get hands out the head that was current.
  assert property (@(posedge clk) disable iff (rst)
    exec_done && exec_cmd == fbpa_pkg::CMD_GET && free_blocks != '0 |=>
      m_axis_tdata[7:0] == $past(head_index))
    else $error("grant differs from list head");

endmodule
